/* rtl/assert_macros.svh */
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAU_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_ASSERT_NR(lbl, prop, msg)
`endif

`endif

/* rtl/cau_pkg.sv */
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int LIN_W         = DATA_W + 1;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int DIV_STEPS     = DATA_W;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MUL   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_CONJ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } clamp_t;

  typedef struct packed {
    op_t                     op;
    logic signed [PROD_W-1:0] p_arbr;
    logic signed [PROD_W-1:0] p_aibi;
    logic signed [PROD_W-1:0] p_arbi;
    logic signed [PROD_W-1:0] p_aibr;
    logic signed [PROD_W-1:0] p_brbr;
    logic signed [PROD_W-1:0] p_bibi;
    logic signed [LIN_W-1:0]  lin_re;
    logic signed [LIN_W-1:0]  lin_im;
    logic                     bzero;
  } mul_t;

  typedef struct packed {
    op_t                     op;
    logic signed [SUM_W-1:0] s_re;
    logic signed [SUM_W-1:0] s_im;
    logic [PROD_W-1:0]       den;
    logic                    bzero;
  } cmb_t;

  typedef struct packed {
    logic              is_div;
    logic              bzero;
    logic              neg_re;
    logic              neg_im;
    logic              sat;
    logic [DATA_W-1:0] res_re;
    logic [DATA_W-1:0] res_im;
  } info_t;

  typedef struct packed {
    info_t             info;
    logic [PROD_W-1:0] mag_re;
    logic [PROD_W-1:0] mag_im;
    logic [PROD_W-1:0] den;
  } fin_t;

  typedef struct packed {
    info_t             info;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] rem_re;
    logic [PROD_W-1:0] rem_im;
    logic [DATA_W-1:0] sh_re;
    logic [DATA_W-1:0] sh_im;
    logic              ovf_re;
    logic              ovf_im;
  } dv_t;

endpackage

/* rtl/cau_in_if.sv */
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;
  logic signed [31:0] scalar;

  modport source (output valid, op, a_re, a_im, b_re, b_im, scalar, input ready);
  modport sink (input valid, op, a_re, a_im, b_re, b_im, scalar, output ready);
endinterface

/* rtl/cau_out_if.sv */
interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic [1:0]         status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink (input valid, res_re, res_im, status, output ready);
endinterface

/* rtl/cau_mult.sv */
module cau_mult (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         op,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  input  logic signed [31:0] scalar,
  output cau_pkg::mul_t      q
);
  import cau_pkg::*;

  mul_t                     mul_r;
  mul_t                     mul_nxt;
  op_t                      op_v;
  logic signed [DATA_W-1:0] y;

  always_comb begin
    op_v = op_t'(op);
    y    = (op_v == OP_SCALE) ? scalar : b_re;
    mul_nxt.op     = op_v;
    mul_nxt.p_arbr = a_re * y;
    mul_nxt.p_aibr = a_im * y;
    mul_nxt.p_aibi = a_im * b_im;
    mul_nxt.p_arbi = a_re * b_im;
    mul_nxt.p_brbr = b_re * b_re;
    mul_nxt.p_bibi = b_im * b_im;
    mul_nxt.bzero  = (b_re == '0) && (b_im == '0);
    case (op_v)
      OP_ADD: begin
        mul_nxt.lin_re = {a_re[DATA_W-1], a_re} + {b_re[DATA_W-1], b_re};
        mul_nxt.lin_im = {a_im[DATA_W-1], a_im} + {b_im[DATA_W-1], b_im};
      end
      OP_CONJ: begin
        mul_nxt.lin_re = {a_re[DATA_W-1], a_re};
        mul_nxt.lin_im = -{a_im[DATA_W-1], a_im};
      end
      default: begin
        mul_nxt.lin_re = '0;
        mul_nxt.lin_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r <= mul_nxt;
    end
  end

  assign q = mul_r;
endmodule

/* rtl/cau_comb.sv */
module cau_comb (
  input  logic          clk,
  input  logic          en,
  input  cau_pkg::mul_t d,
  output cau_pkg::cmb_t q
);
  import cau_pkg::*;

  cmb_t                    cmb_r;
  cmb_t                    cmb_nxt;
  logic signed [SUM_W-1:0] p0;
  logic signed [SUM_W-1:0] p1;
  logic signed [SUM_W-1:0] p2;
  logic signed [SUM_W-1:0] p3;

  always_comb begin
    p0 = {d.p_arbr[PROD_W-1], d.p_arbr};
    p1 = {d.p_aibi[PROD_W-1], d.p_aibi};
    p2 = {d.p_arbi[PROD_W-1], d.p_arbi};
    p3 = {d.p_aibr[PROD_W-1], d.p_aibr};
    cmb_nxt.op    = d.op;
    cmb_nxt.bzero = d.bzero;
    cmb_nxt.den   = d.p_brbr[PROD_W-1:0] + d.p_bibi[PROD_W-1:0];
    case (d.op)
      OP_MUL: begin
        cmb_nxt.s_re = p0 - p1;
        cmb_nxt.s_im = p2 + p3;
      end
      OP_SCALE: begin
        cmb_nxt.s_re = p0;
        cmb_nxt.s_im = p3;
      end
      OP_DIV: begin
        cmb_nxt.s_re = p0 + p1;
        cmb_nxt.s_im = p3 - p2;
      end
      OP_ADD, OP_CONJ: begin
        cmb_nxt.s_re = {{(SUM_W-LIN_W){d.lin_re[LIN_W-1]}}, d.lin_re};
        cmb_nxt.s_im = {{(SUM_W-LIN_W){d.lin_im[LIN_W-1]}}, d.lin_im};
      end
      default: begin
        cmb_nxt.s_re = '0;
        cmb_nxt.s_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmb_r <= cmb_nxt;
    end
  end

  assign q = cmb_r;
endmodule

/* rtl/cau_fin.sv */
module cau_fin #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  cau_pkg::cmb_t d,
  output cau_pkg::fin_t q
);
  import cau_pkg::*;

  fin_t                    fin_r;
  fin_t                    fin_nxt;
  logic signed [SUM_W-1:0] s_re;
  logic signed [SUM_W-1:0] s_im;
  logic signed [SUM_W-1:0] n_re;
  logic signed [SUM_W-1:0] n_im;
  clamp_t                  c_re;
  clamp_t                  c_im;

  function automatic clamp_t clamp_sum(input logic signed [SUM_W-1:0] v);
    clamp_t c;
    if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
      c.val = v[DATA_W-1:0];
      c.sat = 1'b0;
    end else begin
      c.val = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      c.sat = 1'b1;
    end
    return c;
  endfunction

  always_comb begin
    s_re = d.s_re;
    s_im = d.s_im;
    n_re = -s_re;
    n_im = -s_im;
    c_re = '0;
    c_im = '0;
    fin_nxt = '0;
    fin_nxt.den          = d.den;
    fin_nxt.info.bzero   = d.bzero;
    case (d.op)
      OP_MUL, OP_SCALE: begin
        c_re = clamp_sum(s_re >>> FRAC_BITS);
        c_im = clamp_sum(s_im >>> FRAC_BITS);
      end
      OP_ADD, OP_CONJ: begin
        c_re = clamp_sum(s_re);
        c_im = clamp_sum(s_im);
      end
      OP_DIV: begin
        fin_nxt.info.is_div = 1'b1;
        fin_nxt.info.neg_re = s_re[SUM_W-1];
        fin_nxt.info.neg_im = s_im[SUM_W-1];
        fin_nxt.mag_re      = s_re[SUM_W-1] ? n_re[PROD_W-1:0] : s_re[PROD_W-1:0];
        fin_nxt.mag_im      = s_im[SUM_W-1] ? n_im[PROD_W-1:0] : s_im[PROD_W-1:0];
      end
      default: begin
        c_re = '0;
        c_im = '0;
      end
    endcase
    fin_nxt.info.res_re = c_re.val;
    fin_nxt.info.res_im = c_im.val;
    fin_nxt.info.sat    = c_re.sat | c_im.sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign q = fin_r;
endmodule

/* rtl/cau_div_prep.sv */
module cau_div_prep #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  cau_pkg::fin_t d,
  output cau_pkg::dv_t  q
);
  import cau_pkg::*;

  localparam int HI_SH = DATA_W - FRAC_BITS;

  dv_t prep_r;
  dv_t prep_nxt;

  always_comb begin
    prep_nxt.info   = d.info;
    prep_nxt.den    = d.den;
    prep_nxt.rem_re = d.mag_re >> HI_SH;
    prep_nxt.rem_im = d.mag_im >> HI_SH;
    prep_nxt.ovf_re = (d.mag_re >> HI_SH) >= d.den;
    prep_nxt.ovf_im = (d.mag_im >> HI_SH) >= d.den;
    prep_nxt.sh_re  = {d.mag_re[HI_SH-1:0], {FRAC_BITS{1'b0}}};
    prep_nxt.sh_im  = {d.mag_im[HI_SH-1:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign q = prep_r;
endmodule

/* rtl/cau_div_step.sv */
module cau_div_step (
  input  logic         clk,
  input  logic         en,
  input  cau_pkg::dv_t d,
  output cau_pkg::dv_t q
);
  import cau_pkg::*;

  dv_t              step_r;
  dv_t              step_nxt;
  logic [PROD_W:0]  t_re;
  logic [PROD_W:0]  t_im;
  logic [PROD_W:0]  df_re;
  logic [PROD_W:0]  df_im;
  logic             ge_re;
  logic             ge_im;

  always_comb begin
    t_re  = {d.rem_re, d.sh_re[DATA_W-1]};
    t_im  = {d.rem_im, d.sh_im[DATA_W-1]};
    ge_re = t_re >= {1'b0, d.den};
    ge_im = t_im >= {1'b0, d.den};
    df_re = t_re - {1'b0, d.den};
    df_im = t_im - {1'b0, d.den};
    step_nxt        = d;
    step_nxt.rem_re = ge_re ? df_re[PROD_W-1:0] : t_re[PROD_W-1:0];
    step_nxt.rem_im = ge_im ? df_im[PROD_W-1:0] : t_im[PROD_W-1:0];
    step_nxt.sh_re  = {d.sh_re[DATA_W-2:0], ge_re};
    step_nxt.sh_im  = {d.sh_im[DATA_W-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r <= step_nxt;
    end
  end

  assign q = step_r;
endmodule

/* rtl/complex_arith_unit_top.sv */
// Pipeline: multiply, combine, finish, divide prep, divider steps, output register; same at any FRAC_BITS.
// Throughput: one item per cycle; stalls back up stage by stage and bubbles fill.
// Depth is set by the 32-stage restoring divider, one quotient bit per stage.
// Reset (rst_n low at a clock edge) empties the pipeline; data registers keep contents.
`include "assert_macros.svh"

module complex_arith_unit_top #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  cau_in_if.sink   in_ch,
  cau_out_if.source out_ch
);
  import cau_pkg::*;

  localparam int NSTAGE = 4 + DIV_STEPS + 1;
  localparam int S_PREP = 3;

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] valid_nxt;
  logic [NSTAGE-1:0] en;

  mul_t              mul_q;
  cmb_t              cmb_q;
  fin_t              fin_q;
  dv_t               dv [0:DIV_STEPS];

  logic [DATA_W-1:0] res_re_r;
  logic [DATA_W-1:0] res_im_r;
  status_t           status_r;
  clamp_t            o_re;
  clamp_t            o_im;
  logic [DATA_W-1:0] res_re_nxt;
  logic [DATA_W-1:0] res_im_nxt;
  status_t           status_nxt;

  function automatic clamp_t clamp_quo(input logic [DATA_W-1:0] qv, input logic neg,
                                       input logic ovf);
    clamp_t c;
    if (neg) begin
      c.sat = ovf || (qv[DATA_W-1] && (|qv[DATA_W-2:0]));
      c.val = c.sat ? {1'b1, {(DATA_W-1){1'b0}}} : -qv;
    end else begin
      c.sat = ovf || qv[DATA_W-1];
      c.val = c.sat ? {1'b0, {(DATA_W-1){1'b1}}} : qv;
    end
    return c;
  endfunction

  always_comb begin
    en[NSTAGE-1] = !valid_r[NSTAGE-1] || out_ch.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt[0] = en[0] ? in_ch.valid : valid_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  cau_mult u_mult (
    .clk    (clk),
    .en     (en[0]),
    .op     (in_ch.op),
    .a_re   (in_ch.a_re),
    .a_im   (in_ch.a_im),
    .b_re   (in_ch.b_re),
    .b_im   (in_ch.b_im),
    .scalar (in_ch.scalar),
    .q      (mul_q)
  );

  cau_comb u_comb (
    .clk (clk),
    .en  (en[1]),
    .d   (mul_q),
    .q   (cmb_q)
  );

  cau_fin #(.FRAC_BITS(FRAC_BITS)) u_fin (
    .clk (clk),
    .en  (en[2]),
    .d   (cmb_q),
    .q   (fin_q)
  );

  cau_div_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk (clk),
    .en  (en[S_PREP]),
    .d   (fin_q),
    .q   (dv[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    cau_div_step u_step (
      .clk (clk),
      .en  (en[S_PREP+1+i]),
      .d   (dv[i]),
      .q   (dv[i+1])
    );
  end

  always_comb begin
    o_re = clamp_quo(dv[DIV_STEPS].sh_re, dv[DIV_STEPS].info.neg_re, dv[DIV_STEPS].ovf_re);
    o_im = clamp_quo(dv[DIV_STEPS].sh_im, dv[DIV_STEPS].info.neg_im, dv[DIV_STEPS].ovf_im);
    if (!dv[DIV_STEPS].info.is_div) begin
      res_re_nxt = dv[DIV_STEPS].info.res_re;
      res_im_nxt = dv[DIV_STEPS].info.res_im;
      status_nxt = dv[DIV_STEPS].info.sat ? ST_SAT : ST_OK;
    end else if (dv[DIV_STEPS].info.bzero) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = ST_DIVZ;
    end else begin
      res_re_nxt = o_re.val;
      res_im_nxt = o_im.val;
      status_nxt = (o_re.sat || o_im.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_ch.ready   = en[0];
  assign out_ch.valid  = valid_r[NSTAGE-1];
  assign out_ch.res_re = res_re_r;
  assign out_ch.res_im = res_im_r;
  assign out_ch.status = status_r;

  `CAU_ASSERT(a_divz_zero, out_ch.valid && (out_ch.status == ST_DIVZ) |-> (out_ch.res_re == '0) && (out_ch.res_im == '0), "divide by zero item with nonzero result")
  `CAU_ASSERT(a_accept_fill, in_ch.valid && in_ch.ready |=> valid_r[0], "accepted item lost at entry stage")
  `CAU_ASSERT_NR(a_reset_empty, !rst_n |=> (valid_r == '0), "pipeline not empty after reset")

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import cau_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LATENCY = 37;
  localparam logic signed [129:0] MAX32 = 130'sd2147483647;
  localparam logic signed [129:0] MIN32 = -130'sd2147483648;
  localparam logic signed [31:0] PMAX = 32'sh7fffffff;
  localparam logic signed [31:0] PMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         status;
  } cplx_result_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   errors;
  bit   no_idle;
  cplx_result_t pending_results[$];

  cau_in_if  in_ch();
  cau_out_if out_ch();

  complex_arith_unit_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(input logic signed [129:0] v, inout bit s);
    if (v > MAX32) begin
      s = 1'b1;
      return PMAX;
    end
    if (v < MIN32) begin
      s = 1'b1;
      return PMIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [129:0] div_trunc(input logic signed [129:0] n,
                                                    input logic signed [129:0] d);
    logic signed [129:0] mag;
    logic signed [129:0] q;
    mag = (n < 0) ? -n : n;
    q = (mag <<< FB) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_result_t complex_alu_predict(
      input logic [2:0] op, input logic signed [31:0] a_re, a_im, b_re, b_im, sc);
    logic signed [129:0] ar, ai, br, bi, s, den;
    cplx_result_t r;
    bit sat;
    ar = a_re; ai = a_im; br = b_re; bi = b_im; s = sc;
    sat = 1'b0;
    r.re = '0;
    r.im = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        r.re = sat32(ar + br, sat);
        r.im = sat32(ai + bi, sat);
      end
      OP_MUL: begin
        r.re = sat32((ar * br - ai * bi) >>> FB, sat);
        r.im = sat32((ar * bi + ai * br) >>> FB, sat);
      end
      OP_SCALE: begin
        r.re = sat32((s * ar) >>> FB, sat);
        r.im = sat32((s * ai) >>> FB, sat);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.status = ST_DIVZ;
        end else begin
          den = br * br + bi * bi;
          r.re = sat32(div_trunc(ar * br + ai * bi, den), sat);
          r.im = sat32(div_trunc(ai * br - ar * bi, den), sat);
        end
      end
      OP_CONJ: begin
        r.re = sat32(ar, sat);
        r.im = sat32(-ai, sat);
      end
      default: ;
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(input string field, input logic [31:0] exp_v, got_v);
    errors++;
    $display("mismatch %s: expected %h got %h at cycle %0d", field, exp_v, got_v, cycles);
  endtask

  task automatic send(input logic [2:0] op, input logic signed [31:0] a_re, a_im,
                      b_re, b_im, sc);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.a_re   <= a_re;
    in_ch.a_im   <= a_im;
    in_ch.b_re   <= b_re;
    in_ch.b_im   <= b_im;
    in_ch.scalar <= sc;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(complex_alu_predict(op, a_re, a_im, b_re, b_im, sc));
  endtask

  function automatic logic signed [31:0] pick_value(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 << FB)) - (4 <<< FB);
      2: return $signed($urandom_range(0, 511)) - 256;
      3: return $urandom_range(0, 1) ? PMAX - $urandom_range(0, 3)
                                     : PMIN + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 400 << FB)) - (200 <<< FB);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [31:0] v[6];
    v = '{PMAX, PMIN, 32'sd0, ONE, -ONE, 32'sd1};
    for (int op = 0; op < 8; op++) begin
      send(3'(op), PMAX, PMIN, PMAX, PMIN, PMAX);
      send(3'(op), PMIN, PMIN, PMIN, PMAX, PMIN);
    end
    send(OP_DIV, ONE, ONE, 32'sd0, 32'sd0, 32'sd0);
    send(OP_DIV, PMAX, PMIN, 32'sd0, 32'sd0, PMAX);
    send(OP_DIV, PMAX, PMAX, 32'sd1, 32'sd0, 32'sd0);
    send(OP_CONJ, ONE, PMIN, 32'sd0, 32'sd0, 32'sd0);
    send(OP_MUL, -ONE, -32'sd1, 32'sd1, -ONE, 32'sd0);
    for (int i = 0; i < 6; i++) send(OP_SCALE, v[i], v[5 - i], 32'sd0, 32'sd0, v[i]);
  endtask

  task automatic test_random(input int count, input bit full_range);
    int k;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
      k = full_range ? $urandom_range(0, 4) : $urandom_range(1, 4);
      send(3'(($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4)),
           pick_value(k), pick_value(k), pick_value(full_range ? $urandom_range(0, 4) : k),
           ($urandom_range(0, 15) == 0) ? 32'sd0 : pick_value(k), pick_value(k));
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 999);
      if (r < 700) out_ch.ready <= 1'b1;
      else if (r < 990) out_ch.ready <= 1'b0;
      else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cplx_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.res_re !== e.re) report("res_re", e.re, out_ch.res_re);
        if (out_ch.res_im !== e.im) report("res_im", e.im, out_ch.res_im);
        if (out_ch.status !== e.status) report("status", e.status, out_ch.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    no_idle = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= '0;
    in_ch.a_re <= '0;
    in_ch.a_im <= '0;
    in_ch.b_re <= '0;
    in_ch.b_im <= '0;
    in_ch.scalar <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random(600, 1'b0);
    test_random(650, 1'b1);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_in_if.sv
rtl/cau_out_if.sv
rtl/cau_mult.sv
rtl/cau_comb.sv
rtl/cau_fin.sv
rtl/cau_div_prep.sv
rtl/cau_div_step.sv
rtl/complex_arith_unit_top.sv
sim/tb.sv
